/* src/iqb2f_pkg.sv */
package iqb2f_pkg;

	typedef enum logic [1:0] {
		FMT_U8  = 2'd0,
		FMT_S8  = 2'd1,
		FMT_U10 = 2'd2,
		FMT_S10 = 2'd3
	} fmt_t;

	// Raw sample bits of one pair plus the format they were captured under.
	typedef struct packed {
		logic [9:0] i_raw;
		logic [9:0] q_raw;
		fmt_t       fmt;
	} pair_t;

	// Signed value (11 bits covers -512..511) from raw bits.
	function automatic logic signed [10:0] decode_value(input logic [9:0] raw, input fmt_t fmt);
		logic signed [10:0] v;
		begin
			case (fmt)
				FMT_U8:  v = $signed({3'b000, raw[7:0]}) - 11'sd128;
				FMT_S8:  v = {{3{raw[7]}}, raw[7:0]};
				FMT_U10: v = $signed({1'b0, raw}) - 11'sd512;
				FMT_S10: v = {raw[9], raw};
				default: v = '0;
			endcase
			return v;
		end
	endfunction

	// Exact single-precision pattern of v / 2^shift, with shift 7 or 9.
	function automatic logic [31:0] to_f32(input logic signed [10:0] v, input logic wide);
		logic [9:0]  mag;
		logic [3:0]  p;
		logic [7:0]  exp_field;
		logic [22:0] mant;
		logic [32:0] shifted;
		begin
			mag = v[10] ? 10'(-v) : v[9:0];
			if (v == -11'sd512) mag = 10'd0;
			p = 4'd0;
			for (int k = 1; k < 11; k++) begin
				if (k < 10) begin
					if (mag[k]) p = 4'(k);
				end
			end
			if (v == -11'sd512) p = 4'd9;
			exp_field = 8'd127 + {4'd0, p} - (wide ? 8'd9 : 8'd7);
			shifted = {23'd0, mag} << (5'd23 - {1'b0, p});
			mant = shifted[22:0];
			if (v == 11'sd0) return 32'd0;
			return {v[10], exp_field, mant};
		end
	endfunction

endpackage

/* src/iq_bytes_to_float32_unit.sv */
// The result of the request that completes a pair is registered and appears on m_axis in the next cycle.
// Throughput: one byte request per cycle; one result per two or four bytes.
// The input stalls only while a finished result waits and m_axis_tready is low.
// Reset (arst_n low, asynchronous) clears the format to 8-bit unsigned,
// the grouping phase and the output valid flag.
module iq_bytes_to_float32_unit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_data,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	input  logic [7:0]  s_axis_tdata,  // in_byte
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	output logic [63:0] m_axis_tdata   // i_float [31:0], q_float [63:32]
);
	logic take, pair_done, can_load;
	iqb2f_pkg::pair_t pair;

	assign s_axis_tready = can_load;
	assign take = s_axis_tvalid && s_axis_tready;

	iqb2f_group u_group (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
		.take(take), .in_byte(s_axis_tdata), .pair_done(pair_done), .pair(pair)
	);

	iqb2f_convert u_conv (
		.clk(clk), .arst_n(arst_n), .load(pair_done), .pair(pair),
		.out_ready(m_axis_tready), .out_valid(m_axis_tvalid), .out_data(m_axis_tdata),
		.can_load(can_load)
	);
endmodule

/* src/iqb2f_group.sv */
module iqb2f_group (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [1:0]         cfg_data,
	input  logic               take,
	input  logic [7:0]         in_byte,
	output logic               pair_done,
	output iqb2f_pkg::pair_t   pair
);
	iqb2f_pkg::fmt_t fmt_q;
	logic [1:0] phase_q;
	logic [9:0] held_i_q;
	logic [7:0] held_qh_q;
	logic wide;

	assign wide = fmt_q[1];
	assign pair_done = take && (wide ? (phase_q == 2'd3) : phase_q[0]);
	assign pair.fmt = fmt_q;
	assign pair.i_raw = held_i_q;
	assign pair.q_raw = wide ? {held_qh_q, in_byte[1:0]} : {2'b00, in_byte};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fmt_q <= iqb2f_pkg::FMT_U8;
			phase_q <= 2'd0;
			held_i_q <= '0;
			held_qh_q <= '0;
		end else if (cfg_we) begin
			fmt_q <= iqb2f_pkg::fmt_t'(cfg_data);
			phase_q <= 2'd0;
			held_i_q <= '0;
			held_qh_q <= '0;
		end else if (take) begin
			if (!wide) begin
				if (!phase_q[0]) begin
					held_i_q <= {2'b00, in_byte};
					phase_q <= 2'd1;
				end else begin
					phase_q <= 2'd0;
				end
			end else begin
				case (phase_q)
					2'd0: begin
						held_i_q <= {in_byte, 2'b00};
						phase_q <= 2'd1;
					end
					2'd1: begin
						held_i_q <= {held_i_q[9:2], in_byte[1:0]};
						phase_q <= 2'd2;
					end
					2'd2: begin
						held_qh_q <= in_byte;
						phase_q <= 2'd3;
					end
					default: phase_q <= 2'd0;
				endcase
			end
		end
	end

	a_phase_narrow: assert property (@(posedge clk) disable iff (!arst_n)
		(!fmt_q[1] && !$past(cfg_we)) |-> (phase_q[1] == 1'b0)) else $error("phase range");
	a_cfg_restart: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_we |=> (phase_q == 2'd0)) else $error("restart");
	a_done_phase: assert property (@(posedge clk) disable iff (!arst_n)
		(pair_done && !cfg_we) |=> (phase_q == 2'd0)) else $error("done phase");
endmodule

/* src/iqb2f_convert.sv */
module iqb2f_convert (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  iqb2f_pkg::pair_t pair,
	input  logic             out_ready,
	output logic             out_valid,
	output logic [63:0]      out_data,
	output logic             can_load
);
	logic [31:0] i_f, q_f;
	logic valid_q;
	logic [63:0] data_q;

	assign i_f = iqb2f_pkg::to_f32(iqb2f_pkg::decode_value(pair.i_raw, pair.fmt), pair.fmt[1]);
	assign q_f = iqb2f_pkg::to_f32(iqb2f_pkg::decode_value(pair.q_raw, pair.fmt), pair.fmt[1]);
	assign can_load = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign out_data = data_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) data_q <= {q_f, i_f};
	end

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_q && !out_ready) |=> (valid_q && $stable(data_q))) else $error("overwrite");
endmodule
